/* src/assert_macros.svh */
// Assertion macros used by the checker file of the sigmoid neuron trainer.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SNL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("snl assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define SNL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("snl assertion failed");

`endif

/* src/snl_pkg.sv */
// Package for the sigmoid neuron trainer: widths, register indexes, reset values,
// the lane control struct and the elaboration-time sigmoid table builder. No dependencies.
`default_nettype none

package snl_pkg;

    localparam int NUM_FEATURES    = 3;
    localparam int SIGMOID_ENTRIES = 1024;
    localparam int SIG_AW          = $clog2(SIGMOID_ENTRIES);

    localparam int FEAT_W   = 16;
    localparam int WGT_W    = 32;
    localparam int PROD_W   = FEAT_W + WGT_W;
    localparam int SUM_W    = PROD_W + $clog2(NUM_FEATURES) + 1;
    localparam int SIG_Y_W  = 12;
    localparam int Y_W      = 13;
    localparam int TGT_W    = 13;
    localparam int E_W      = 14;
    localparam int RATING_W = 17;
    localparam int ETA_W    = 32;
    localparam int P_W      = FEAT_W + E_W;
    localparam int MAG_W    = 28;
    localparam int M_W      = MAG_W + ETA_W;
    localparam int D_W      = M_W - 31;
    localparam int GAIN_W   = 16;
    localparam int GY_W     = GAIN_W + SIG_Y_W;
    localparam int ERRS_W   = 32;
    localparam int BOUND_W  = 24;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int IN_DATA_W  = ((NUM_FEATURES * FEAT_W + TGT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((Y_W + E_W + RATING_W + 7) / 8) * 8;

    localparam logic [TGT_W-1:0] TARGET_ONE = TGT_W'(4096);

    localparam logic [ETA_W-1:0]          LEARN_RATE_RST  = 32'd214748;
    localparam logic signed [WGT_W-1:0]   WEIGHT_RST      = 32'sd8388608;
    localparam logic [BOUND_W-1:0]        FIRST_BOUND_RST = 24'd270336;
    localparam logic [GAIN_W-1:0]         GAIN_RST        = 16'd5000;
    localparam logic [GAIN_W-1:0]         OFFSET_RST      = 16'd123;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEARN_RATE  = 3'd0,
        CFG_INIT_A      = 3'd1,
        CFG_INIT_B      = 3'd2,
        CFG_INIT_C      = 3'd3,
        CFG_FIRST_BOUND = 3'd4,
        CFG_GAIN        = 3'd5,
        CFG_OFFSET      = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic mul;
        logic err;
        logic scale;
        logic upd;
        logic load;
    } t_lane_ctl;

    typedef logic [SIG_Y_W-1:0] t_sig_table [SIGMOID_ENTRIES];

    // Restoring long division, used only while the table is built at elaboration.
    function automatic logic [63:0] snl_udiv(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            r = {r[62:0], num[b]};
            if (r >= den) begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // Sigmoid of the bucket midpoint, Q0.12, from a Taylor series of exp(-|x|/32)
    // raised to the 16th power by four roundings of squares.
    function automatic logic [SIG_Y_W-1:0] snl_sig_entry(input int idx);
        logic [63:0]        num;
        logic signed [63:0] x;
        logic [63:0]        t;
        logic [63:0]        u;
        logic [63:0]        term;
        logic signed [63:0] acc;
        logic [63:0]        v;
        logic [63:0]        den;
        logic [63:0]        s;
        num  = 64'(2 * idx + 1) << 35;
        x    = $signed(num >> SIG_AW) - 64'sd34359738368;
        t    = (x < 0) ? 64'(-x) : 64'(x);
        u    = t >> 5;
        term = 64'd1 << 31;
        acc  = $signed(term);
        for (int k = 1; k <= 14; k++) begin
            term = snl_udiv((term * u) >> 31, 64'(k));
            if ((k % 2) == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        v = 64'(acc);
        for (int n = 0; n < 4; n++) begin
            v = (v * v + (64'd1 << 30)) >> 31;
        end
        den = (64'd1 << 31) + v;
        if (x >= 0) begin
            s = snl_udiv((64'd1 << 43) + (den >> 1), den);
        end else begin
            s = snl_udiv(v * 64'd4096 + (den >> 1), den);
        end
        return (s > 64'd4095) ? SIG_Y_W'(4095) : s[SIG_Y_W-1:0];
    endfunction

    function automatic t_sig_table snl_build_table();
        t_sig_table tbl;
        for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
            tbl[i] = snl_sig_entry(i);
        end
        return tbl;
    endfunction

endpackage

`default_nettype wire

/* src/snl_lane.sv */
// One weight lane: holds a weight, forms feature times weight for the dot product
// and applies the rounded, saturated delta-rule step. Depends on snl_pkg.
`default_nettype none

module snl_lane
    import snl_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire t_lane_ctl                 i_ctl,
    input  wire logic signed [FEAT_W-1:0]  i_x,
    input  wire logic signed [E_W-1:0]     i_e,
    input  wire logic [ETA_W-1:0]          i_eta,
    input  wire logic signed [WGT_W-1:0]   i_init,
    output logic signed [PROD_W-1:0]       o_prod
);

    logic signed [WGT_W-1:0]  r_weight;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [P_W-1:0]    r_p;
    logic [M_W-1:0]           r_m;
    logic                     r_neg;

    logic signed [PROD_W-1:0] prod_full;
    logic signed [P_W-1:0]    p_full;
    logic signed [P_W-1:0]    p_abs;
    logic [M_W-1:0]           m_full;
    logic [M_W:0]             m_round;
    logic [D_W-1:0]           d_mag;
    logic signed [WGT_W+1:0]  w_ext;
    logic signed [WGT_W+1:0]  d_ext;
    logic signed [WGT_W+1:0]  w_sum;
    logic signed [WGT_W-1:0]  n_weight;

    always_comb begin
        prod_full = i_x * r_weight;
        p_full    = i_x * i_e;
        p_abs     = (r_p < 0) ? -r_p : r_p;
        m_full    = MAG_W'(p_abs) * i_eta;
        m_round   = {1'b0, r_m} + (M_W + 1)'(64'd1 << 31);
        d_mag     = m_round[M_W:32];
        w_ext     = (WGT_W + 2)'(r_weight);
        d_ext     = $signed({{(WGT_W + 2 - D_W){1'b0}}, d_mag});
        w_sum     = r_neg ? (w_ext - d_ext) : (w_ext + d_ext);
        if (w_sum > (WGT_W + 2)'(32'sh7FFF_FFFF)) begin
            n_weight = {1'b0, {(WGT_W - 1){1'b1}}};
        end else if (w_sum < -(WGT_W + 2)'(33'sh0_8000_0000)) begin
            n_weight = {1'b1, {(WGT_W - 1){1'b0}}};
        end else begin
            n_weight = w_sum[WGT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= WEIGHT_RST;
        end else if (i_ctl.load) begin
            r_weight <= i_init;
        end else if (i_ctl.upd) begin
            r_weight <= n_weight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul) begin
            r_prod <= prod_full;
        end
        if (i_ctl.err) begin
            r_p <= p_full;
        end
        if (i_ctl.scale) begin
            r_m   <= m_full;
            r_neg <= (r_p < 0);
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

/* src/snl_merge.sv */
// Merging stage: adds the lane products into the dot product and turns the
// registered sum into a clamped sigmoid table address. Depends on snl_pkg.
`default_nettype none

module snl_merge
    import snl_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [PROD_W-1:0]  i_prod [NUM_FEATURES],
    output logic [SIG_AW-1:0]              o_addr
);

    localparam logic signed [SUM_W-1:0] SUM_LIM = {{(SUM_W - 40){1'b0}}, 1'b1, 39'b0};

    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] n_sum;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < NUM_FEATURES; j++) begin
            n_sum = n_sum + SUM_W'(i_prod[j]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= n_sum;
        end
    end

    always_comb begin
        if (r_sum >= SUM_LIM) begin
            o_addr = {SIG_AW{1'b1}};
        end else if (r_sum < -SUM_LIM) begin
            o_addr = '0;
        end else begin
            o_addr = {~r_sum[39], r_sum[38 -: (SIG_AW - 1)]};
        end
    end

endmodule

`default_nettype wire

/* src/snl_sigmoid_rom.sv */
// Sigmoid lookup ROM with a registered read port; contents are built at
// elaboration by the table function of snl_pkg.
`default_nettype none

module snl_sigmoid_rom
    import snl_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [SIG_AW-1:0] i_addr,
    output logic [SIG_Y_W-1:0]     o_data
);

    localparam t_sig_table SIG_TABLE = snl_build_table();

    logic [SIG_Y_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= SIG_TABLE[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

/* src/sigmoid_neuron_online_trainer.sv */
// Top level of the sigmoid neuron trainer: stream ports, configuration registers,
// sequencer, epoch bookkeeping and output register. Uses snl_pkg, snl_lane,
// snl_merge and snl_sigmoid_rom.
//
//  Channel   Direction  Handshake          Contents
//  s_axis    in         tvalid / tready    tdata features and target, tuser type, tlast epoch end
//  m_axis    out        tvalid / tready    tdata output, error, rating, tuser converged, tlast done
//  cfg       in         we, no wait        idx selects the register, data is the value
//
// An item steps through MUL, SUM, LOOK, ERR, SCALE and UPD before its result is registered.
// The chain of lane multiply, merge add, table read and the two update multiplies sets this.
// A new item is accepted when the sequencer is idle, even while a result waits to be taken.
// Reset is synchronous and active low; weights return to their reset values.
// A stalled output holds the sequencer in its last step until the result register frees.
`default_nettype none

module sigmoid_neuron_online_trainer
    import snl_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // feature_a [15:0], feature_b [31:16], feature_c [47:32], target [60:48]
    input  wire logic [IN_DATA_W-1:0]   i_s_axis_tdata,
    // req_type [0]
    input  wire logic                   i_s_axis_tuser,
    input  wire logic                   i_s_axis_tlast,
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    // neuron_out [12:0], sample_error [26:13], rating [43:27]
    output logic [OUT_DATA_W-1:0]       o_m_axis_tdata,
    // converged [0]
    output logic                        o_m_axis_tuser,
    output logic                        o_m_axis_tlast,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_SUM   = 7'b0000100,
        ST_LOOK  = 7'b0001000,
        ST_ERR   = 7'b0010000,
        ST_SCALE = 7'b0100000,
        ST_UPD   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [ETA_W-1:0]         r_eta;
    logic [GAIN_W-1:0]        r_gain;
    logic [GAIN_W-1:0]        r_offset;
    logic [ERRS_W-1:0]        r_err_sum;
    logic [ERRS_W-1:0]        r_last_err;
    logic                     r_stopped;

    logic                     r_req;
    logic signed [FEAT_W-1:0] r_x [NUM_FEATURES];
    logic [TGT_W-1:0]         r_target;
    logic                     r_last;
    logic signed [E_W-1:0]    r_e;
    logic [GY_W-1:0]          r_gain_y;

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;
    logic                     r_out_user;
    logic                     r_out_last;

    logic                     accept;
    logic                     out_free;
    logic                     finish;
    logic                     train_en;
    logic [TGT_W-1:0]         in_target;
    logic signed [E_W-1:0]    e_comb;
    logic [E_W-1:0]           e_abs;
    logic [ERRS_W:0]          err_add;
    logic [ERRS_W-1:0]        err_sat;
    logic [RATING_W-1:0]      rating_scaled;
    logic signed [RATING_W:0] rating_full;
    logic [RATING_W-1:0]      rating;
    logic                     n_stopped;
    logic                     done;

    t_lane_ctl                lane_ctl [NUM_FEATURES];
    logic signed [PROD_W-1:0] lane_prod [NUM_FEATURES];
    logic [SIG_AW-1:0]        rom_addr;
    logic [SIG_Y_W-1:0]       r_y;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign finish          = (r_state == ST_UPD) && out_free;
    assign train_en        = !r_req && !r_stopped;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  begin
                if (accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL:   n_state = ST_SUM;
            ST_SUM:   n_state = ST_LOOK;
            ST_LOOK:  n_state = ST_ERR;
            ST_ERR:   n_state = ST_SCALE;
            ST_SCALE: n_state = ST_UPD;
            ST_UPD:   begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        in_target = i_s_axis_tdata[NUM_FEATURES*FEAT_W +: TGT_W];
        if (in_target > TARGET_ONE) begin
            in_target = TARGET_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req    <= i_s_axis_tuser;
            r_target <= in_target;
            r_last   <= i_s_axis_tlast;
            for (int j = 0; j < NUM_FEATURES; j++) begin
                r_x[j] <= $signed(i_s_axis_tdata[j*FEAT_W +: FEAT_W]);
            end
        end
    end

    always_comb begin
        for (int j = 0; j < NUM_FEATURES; j++) begin
            lane_ctl[j].mul   = (r_state == ST_MUL);
            lane_ctl[j].err   = (r_state == ST_ERR);
            lane_ctl[j].scale = (r_state == ST_SCALE);
            lane_ctl[j].upd   = finish && train_en;
            lane_ctl[j].load  = i_cfg_we
                && (i_cfg_idx == CFG_IDX_W'(int'(CFG_INIT_A) + (j % 3)));
        end
    end

    for (genvar g = 0; g < NUM_FEATURES; g++) begin : g_lane
        snl_lane u_lane (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (lane_ctl[g]),
            .i_x     (r_x[g]),
            .i_e     (e_comb),
            .i_eta   (r_eta),
            .i_init  ($signed(i_cfg_data)),
            .o_prod  (lane_prod[g])
        );
    end

    snl_merge u_merge (
        .i_clk  (i_clk),
        .i_en   (r_state == ST_SUM),
        .i_prod (lane_prod),
        .o_addr (rom_addr)
    );

    snl_sigmoid_rom u_rom (
        .i_clk  (i_clk),
        .i_en   (r_state == ST_LOOK),
        .i_addr (rom_addr),
        .o_data (r_y)
    );

    always_comb begin
        if (r_req) begin
            e_comb = '0;
        end else begin
            e_comb = $signed({1'b0, r_target}) - $signed({2'b0, r_y});
        end
        e_abs         = (r_e < 0) ? E_W'(-r_e) : E_W'(r_e);
        err_add       = {1'b0, r_err_sum} + (ERRS_W + 1)'(e_abs);
        err_sat       = err_add[ERRS_W] ? {ERRS_W{1'b1}} : err_add[ERRS_W-1:0];
        rating_scaled = RATING_W'(((GY_W + 1)'(r_gain_y) + (GY_W + 1)'(2048)) >> 12);
        rating_full   = $signed({1'b0, rating_scaled}) - $signed({2'b0, r_offset});
        rating        = r_req ? rating_full[RATING_W-1:0] : '0;
        done          = train_en && r_last;
        n_stopped     = r_stopped || (done && (err_sat > r_last_err));
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_ERR) begin
            r_e      <= e_comb;
            r_gain_y <= r_gain * r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eta      <= LEARN_RATE_RST;
            r_gain     <= GAIN_RST;
            r_offset   <= OFFSET_RST;
            r_err_sum  <= '0;
            r_last_err <= ERRS_W'(FIRST_BOUND_RST);
            r_stopped  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_LEARN_RATE:  r_eta      <= i_cfg_data[ETA_W-1:0];
                    CFG_FIRST_BOUND: r_last_err <= ERRS_W'(i_cfg_data[BOUND_W-1:0]);
                    CFG_GAIN:        r_gain     <= i_cfg_data[GAIN_W-1:0];
                    CFG_OFFSET:      r_offset   <= i_cfg_data[GAIN_W-1:0];
                    default:         ;
                endcase
            end
            if (finish && train_en) begin
                r_stopped <= n_stopped;
                if (r_last) begin
                    r_err_sum <= '0;
                    if (!(err_sat > r_last_err)) begin
                        r_last_err <= err_sat;
                    end
                end else begin
                    r_err_sum <= err_sat;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out_data <= OUT_DATA_W'({rating, r_e, {1'b0, r_y}});
            r_out_user <= n_stopped;
            r_out_last <= done;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

/* src/snl_checker.sv */
// Port-level checker for the sigmoid neuron trainer, bound to the top level.
// Depends on snl_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module snl_checker
    import snl_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_s_axis_tvalid,
    input wire logic                   o_s_axis_tready,
    input wire logic                   o_m_axis_tvalid,
    input wire logic                   i_m_axis_tready,
    input wire logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    input wire logic                   o_m_axis_tuser,
    input wire logic                   o_m_axis_tlast
);

    logic r_seen_conv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_conv <= 1'b0;
        end else if (o_m_axis_tvalid && i_m_axis_tready && o_m_axis_tuser) begin
            r_seen_conv <= 1'b1;
        end
    end

    `SNL_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    `SNL_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready)
    `SNL_ASSERT_SAME(a_conv_sticky, i_clk, i_rst_n, o_m_axis_tvalid && r_seen_conv, o_m_axis_tuser)
    `SNL_ASSERT_SAME(a_epoch_no_rating, i_clk, i_rst_n, o_m_axis_tvalid && o_m_axis_tlast, o_m_axis_tdata[43:27] == 17'd0)

endmodule

bind sigmoid_neuron_online_trainer snl_checker u_snl_checker (.*);

`default_nettype wire

/* dv/testbench.sv */
// Testbench for the sigmoid neuron trainer: streams train and predict transactions with random
// stalls on both sides and checks every result against a fixed-point model of the neuron.
// Depends on snl_pkg and the sigmoid_neuron_online_trainer RTL.
`timescale 1ns / 100ps

module testbench;
    import snl_pkg::*;

    typedef longint unsigned u64;
    typedef longint s64;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 20;
    localparam int NUM_PHASES = 11;
    localparam int ITEMS_PER_PHASE = 128;
    localparam u64 ONE_Q12 = 64'd4096;
    localparam s64 LUT_LIMIT = 64'sd549755813888;
    localparam s64 WEIGHT_MAX = 64'sd2147483647;
    localparam s64 WEIGHT_MIN = -64'sd2147483648;

    typedef enum logic {REQ_TRAIN = 1'b0, REQ_PREDICT = 1'b1} t_req_kind;

    typedef struct {
        t_req_kind                kind;
        logic signed [FEAT_W-1:0] feature [NUM_FEATURES];
        logic [TGT_W-1:0]         target;
        logic                     epoch_last;
    } t_neuron_req;

    typedef struct {
        logic [Y_W-1:0]      neuron_out;
        logic [E_W-1:0]      sample_error;
        logic [RATING_W-1:0] rating;
        logic                epoch_done;
        logic                converged;
    } t_neuron_resp;

    class neuron_scoreboard;
        logic [ETA_W-1:0]        learn_rate;
        logic [GAIN_W-1:0]       gain;
        logic [GAIN_W-1:0]       offset;
        logic signed [WGT_W-1:0] weight [NUM_FEATURES];
        u64                      epoch_total;
        u64                      kept_total;
        bit                      stopped;
        logic [SIG_Y_W-1:0]      sig_lut [SIGMOID_ENTRIES];
        t_neuron_resp            expected_q [$];
        int                      errors;
        int                      checked;
        int                      epochs;

        function new();
            for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
                sig_lut[i] = sig_point(i);
            end
            learn_rate = 32'd214748;
            gain = 16'd5000;
            offset = 16'd123;
            for (int j = 0; j < NUM_FEATURES; j++) begin
                weight[j] = 32'sd8388608;
            end
            epoch_total = 0;
            kept_total = 64'd270336;
            stopped = 0;
            errors = 0;
            checked = 0;
            epochs = 0;
        endfunction

        // Sigmoid at the bucket midpoint: exp(-|x|/32) by a Taylor series, then squared
        // four times with rounding.
        function automatic logic [SIG_Y_W-1:0] sig_point(int i);
            s64 x;
            s64 acc;
            u64 mag;
            u64 u;
            u64 term;
            u64 v;
            u64 den;
            u64 q;
            x = s64'((u64'(2 * i + 1) << 35) / u64'(SIGMOID_ENTRIES)) - (s64'(1) << 35);
            mag = (x < 0) ? u64'(-x) : u64'(x);
            u = mag >> 5;
            term = u64'(1) << 31;
            acc = s64'(term);
            for (int k = 1; k <= 14; k++) begin
                term = ((term * u) >> 31) / u64'(k);
                if (k % 2 == 1) begin
                    acc = acc - s64'(term);
                end else begin
                    acc = acc + s64'(term);
                end
            end
            v = u64'(acc);
            repeat (4) v = (v * v + (u64'(1) << 30)) >> 31;
            den = (u64'(1) << 31) + v;
            if (x >= 0) begin
                q = ((u64'(1) << 43) + den / 2) / den;
            end else begin
                q = (v * 64'd4096 + den / 2) / den;
            end
            return (q > 64'd4095) ? SIG_Y_W'(4095) : SIG_Y_W'(q);
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            int k;
            k = int'(idx) - int'(CFG_INIT_A);
            case (idx)
                CFG_LEARN_RATE: learn_rate = value;
                CFG_INIT_A, CFG_INIT_B, CFG_INIT_C: begin
                    for (int j = 0; j < NUM_FEATURES; j++) begin
                        if (j % 3 == k) weight[j] = value;
                    end
                end
                CFG_FIRST_BOUND: kept_total = u64'(value[BOUND_W-1:0]);
                CFG_GAIN: gain = value[GAIN_W-1:0];
                CFG_OFFSET: offset = value[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        function automatic logic [SIG_Y_W-1:0] activation(t_neuron_req r);
            s64 acc;
            u64 idx;
            acc = 0;
            for (int j = 0; j < NUM_FEATURES; j++) begin
                acc = acc + s64'(r.feature[j]) * s64'(weight[j]);
            end
            if (acc > LUT_LIMIT) acc = LUT_LIMIT;
            if (acc < -LUT_LIMIT) acc = -LUT_LIMIT;
            idx = (u64'(acc + LUT_LIMIT) * u64'(SIGMOID_ENTRIES)) >> 40;
            if (idx > u64'(SIGMOID_ENTRIES - 1)) idx = u64'(SIGMOID_ENTRIES - 1);
            return sig_lut[idx];
        endfunction

        function automatic u64 clamped_target(t_neuron_req r);
            return (u64'(r.target) > ONE_Q12) ? ONE_Q12 : u64'(r.target);
        endfunction

        // Epoch error total as it would stand after this training transaction.
        function automatic u64 total_after(t_neuron_req r);
            s64 e;
            e = s64'(clamped_target(r)) - s64'(activation(r));
            return epoch_total + u64'((e < 0) ? -e : e);
        endfunction

        function void note_input(t_neuron_req r);
            t_neuron_resp resp;
            logic [SIG_Y_W-1:0] y;
            s64 e;
            s64 p;
            s64 d;
            s64 w;
            s64 score;
            u64 m;
            bit done;
            y = activation(r);
            e = 0;
            score = 0;
            done = 0;
            if (r.kind == REQ_PREDICT) begin
                score = s64'((u64'(gain) * u64'(y) + 64'd2048) >> 12) - s64'(offset);
            end else begin
                e = s64'(clamped_target(r)) - s64'(y);
                if (!stopped) begin
                    epoch_total = epoch_total + u64'((e < 0) ? -e : e);
                    if (epoch_total > 64'hFFFF_FFFF) epoch_total = 64'hFFFF_FFFF;
                    for (int j = 0; j < NUM_FEATURES; j++) begin
                        p = s64'(r.feature[j]) * e;
                        m = u64'((p < 0) ? -p : p) * u64'(learn_rate);
                        d = s64'((m + (u64'(1) << 31)) >> 32);
                        w = s64'(weight[j]) + ((p < 0) ? -d : d);
                        if (w > WEIGHT_MAX) w = WEIGHT_MAX;
                        if (w < WEIGHT_MIN) w = WEIGHT_MIN;
                        weight[j] = WGT_W'(w);
                    end
                    if (r.epoch_last) begin
                        done = 1;
                        epochs++;
                        if (epoch_total > kept_total) begin
                            stopped = 1;
                        end else begin
                            kept_total = epoch_total;
                        end
                        epoch_total = 0;
                    end
                end
            end
            resp.neuron_out = Y_W'(y);
            resp.sample_error = E_W'(e);
            resp.rating = RATING_W'(score);
            resp.epoch_done = done;
            resp.converged = stopped;
            expected_q.push_back(resp);
        endfunction

        function void compare_field(string name, s64 want, s64 got);
            if (want != got) begin
                errors++;
                if (errors <= 40) $error("%s: expected %0d, actual %0d", name, want, got);
            end
        endfunction

        function void check_result(t_neuron_resp got);
            t_neuron_resp want;
            if (expected_q.size() == 0) begin
                errors++;
                $error("result transaction with no input pending");
                return;
            end
            want = expected_q.pop_front();
            checked++;
            compare_field("neuron_out", s64'(want.neuron_out), s64'(got.neuron_out));
            compare_field("sample_error", s64'($signed(want.sample_error)),
                          s64'($signed(got.sample_error)));
            compare_field("rating", s64'($signed(want.rating)), s64'($signed(got.rating)));
            compare_field("epoch_done", s64'(want.epoch_done), s64'(got.epoch_done));
            compare_field("converged", s64'(want.converged), s64'(got.converged));
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  s_axis_tlast = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    neuron_scoreboard sb = new();
    bit steady = 1'b0;
    int n_train = 0;
    int n_predict = 0;
    int stall_cycles = 0;

    always #5 i_clk = ~i_clk;

    sigmoid_neuron_online_trainer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tlast  (s_axis_tlast),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser),
        .o_m_axis_tlast  (m_axis_tlast),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 45) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic signed [FEAT_W-1:0] random_feature();
        case ($urandom_range(0, 5))
            0: return FEAT_W'($urandom);
            1: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            2: return '0;
            default: return FEAT_W'($urandom_range(0, 8192) - 4096);
        endcase
    endfunction

    function automatic t_neuron_req make_req(t_req_kind kind, int fa, int fb, int fc, int tgt,
                                             bit last);
        t_neuron_req r;
        r.kind = kind;
        r.feature[0] = FEAT_W'(fa);
        r.feature[1] = FEAT_W'(fb);
        r.feature[2] = FEAT_W'(fc);
        r.target = TGT_W'(tgt);
        r.epoch_last = last;
        return r;
    endfunction

    function automatic t_neuron_req random_req();
        t_neuron_req r;
        r.kind = ($urandom_range(0, 4) == 0) ? REQ_PREDICT : REQ_TRAIN;
        for (int j = 0; j < NUM_FEATURES; j++) begin
            r.feature[j] = random_feature();
        end
        r.target = ($urandom_range(0, 9) == 0) ? TGT_W'($urandom) : TGT_W'($urandom_range(0, 4096));
        r.epoch_last = (r.kind == REQ_PREDICT) ? 1'($urandom_range(0, 1)) : 1'b0;
        return r;
    endfunction

    task automatic idle_gap(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send_item(t_neuron_req r);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'({r.target, r.feature[2], r.feature[1], r.feature[0]});
        s_axis_tuser <= r.kind;
        s_axis_tlast <= r.epoch_last;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(r);
        if (r.kind == REQ_PREDICT) n_predict++;
        else n_train++;
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        sb.apply_reg(idx, value);
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_weight();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return '0;
            3: return $urandom;
            default: return $urandom_range(0, 1 << 25) - (1 << 24);
        endcase
    endfunction

    task automatic program_phase(int ph, bit last_phase);
        logic [CFG_DATA_W-1:0] eta;
        case (ph % 5)
            0: eta = 32'hFFFF_FFFF;
            1: eta = '0;
            2: eta = $urandom;
            3: eta = 32'd214748;
            default: eta = $urandom_range(1 << 16, 1 << 26);
        endcase
        cfg_write(CFG_LEARN_RATE, eta);
        if (ph % 3 != 2) begin
            cfg_write(CFG_INIT_A, pick_weight());
            cfg_write(CFG_INIT_B, pick_weight());
            cfg_write(CFG_INIT_C, pick_weight());
        end
        if (last_phase) cfg_write(CFG_FIRST_BOUND, '0);
        else if (ph == 2) cfg_write(CFG_FIRST_BOUND, 32'h00FF_FFFF);
        else cfg_write(CFG_FIRST_BOUND, $urandom_range(1 << 22, 32'h00FF_FFFF));
        cfg_write(CFG_GAIN, (ph % 4 == 0) ? 32'hFFFF : (ph % 4 == 1) ? 32'h0 : $urandom_range(0, 65535));
        cfg_write(CFG_OFFSET, (ph % 4 == 0) ? 32'h0 : (ph % 4 == 1) ? 32'hFFFF : $urandom_range(0, 65535));
        if (ph == 3) cfg_write(CFG_SPARE, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Epoch ends are placed so that a total never exceeds the kept one, except in the last
    // phase, where the bound is zero and training is allowed to stop.
    task automatic run_random(int count, bit last_phase);
        t_neuron_req r;
        u64 tot;
        int ep_count;
        int ep_len;
        ep_count = 0;
        ep_len = $urandom_range(4, 60);
        for (int i = 0; i < count; i++) begin
            idle_gap(pick_gap());
            r = random_req();
            if (r.kind == REQ_TRAIN) begin
                if (last_phase) begin
                    r.epoch_last = ($urandom_range(0, 5) == 0);
                end else if (!sb.stopped && sb.kept_total >= 8 * ONE_Q12) begin
                    tot = sb.total_after(r);
                    ep_count++;
                    if (tot <= sb.kept_total &&
                        (ep_count >= ep_len || tot + ONE_Q12 > sb.kept_total)) begin
                        r.epoch_last = 1'b1;
                        ep_count = 0;
                        ep_len = $urandom_range(4, 60);
                    end
                end
            end
            send_item(r);
        end
    endtask

    task automatic run_directed();
        t_neuron_req plan [$];
        plan.push_back(make_req(REQ_PREDICT, 0, 0, 0, 0, 0));
        plan.push_back(make_req(REQ_PREDICT, 32767, 32767, 32767, 0, 0));
        plan.push_back(make_req(REQ_PREDICT, -32768, -32768, -32768, 0, 0));
        plan.push_back(make_req(REQ_TRAIN, 4096, 4096, 4096, 0, 0));
        plan.push_back(make_req(REQ_TRAIN, -4096, -4096, -4096, 4096, 0));
        plan.push_back(make_req(REQ_TRAIN, 32767, -32768, 0, 8191, 0));
        plan.push_back(make_req(REQ_TRAIN, 100, -200, 300, 4097, 0));
        plan.push_back(make_req(REQ_PREDICT, 1000, -1000, 2000, 0, 1));
        plan.push_back(make_req(REQ_TRAIN, -32768, -32768, -32768, 2048, 0));
        plan.push_back(make_req(REQ_TRAIN, 32767, 32767, 32767, 0, 0));
        plan.push_back(make_req(REQ_TRAIN, 0, 0, 0, 2048, 0));
        plan.push_back(make_req(REQ_TRAIN, 2048, -2048, 1024, 3000, 1));
        plan.push_back(make_req(REQ_PREDICT, 4096, 0, 0, 0, 0));
        plan.push_back(make_req(REQ_TRAIN, 'h5555, 'hAAAA, 'h00FF, 'h1555, 0));
        plan.push_back(make_req(REQ_TRAIN, 'hAAAA, 'h5555, 'hFF00, 'h0AAA, 0));
        plan.push_back(make_req(REQ_PREDICT, 'h7FFF, 'h8000, 'h0001, 'h1FFF, 0));
        foreach (plan[i]) begin
            idle_gap(pick_gap());
            send_item(plan[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_neuron_resp got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.neuron_out = m_axis_tdata[12:0];
            got.sample_error = m_axis_tdata[26:13];
            got.rating = m_axis_tdata[43:27];
            got.epoch_done = m_axis_tlast;
            got.converged = m_axis_tuser;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("no transaction for %0d cycles", stall_cycles);
            $display("testbench: done, errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            m_axis_tready <= 1'b1;
            repeat ($urandom_range(1, 24)) @(posedge i_clk);
            n = pick_gap();
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        wait_idle();
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            steady = (ph % 4 == 3);
            program_phase(ph, ph == NUM_PHASES - 1);
            run_random(ITEMS_PER_PHASE, ph == NUM_PHASES - 1);
            wait_idle();
        end
        $display("Covered %0d training and %0d predict transactions over %0d register settings.",
                 n_train, n_predict, NUM_PHASES + 1);
        $display("Checked %0d results, %0d epochs closed, training %s at the end.",
                 sb.checked, sb.epochs, sb.stopped ? "stopped" : "still active");
        if (sb.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/snl_pkg.sv
src/snl_lane.sv
src/snl_merge.sv
src/snl_sigmoid_rom.sv
src/sigmoid_neuron_online_trainer.sv
src/snl_checker.sv
dv/testbench.sv
